/* src/bdll_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_pkg
// Types and constants shared by the bounded doubly linked list block.
// ----------------------------------------------------------------------------
package bdll_pkg;

    localparam int VAL_W       = 32;
    localparam int POS_W       = 8;
    localparam int OUT_CNT_W   = 5;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_END   = 2'd1,
        OP_DELETE    = 2'd2,
        OP_DISPLAY   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_SCAN,
        S_INS_LINK,
        S_DEL_WALK,
        S_DISP,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  load;
        logic  scan_step;
        logic  link;
        logic  walk_step;
        logic  unlink;
        logic  disp_emit;
        logic  emit;
        logic  rd_cur;
        stat_t emit_status;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic pos_bad;
        logic cand_ready;
        logic steps_zero;
        logic disp_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* src/bdll_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_ctrl
// Sequencer for the list operations: decides, scans, walks and emits words.
// ----------------------------------------------------------------------------
module bdll_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bdll_pkg::dp_stat_t stat,
    output bdll_pkg::ctl_cmd_t cmd
);

    bdll_pkg::state_t state_reg, state_next;
    bdll_pkg::stat_t  res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdll_pkg::S_IDLE;
            res_reg   <= bdll_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            bdll_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = bdll_pkg::S_DECIDE;
            end
            bdll_pkg::S_DECIDE:
            begin
                res_next = bdll_pkg::ST_OK;
                case (stat.op)
                    bdll_pkg::OP_INS_FRONT, bdll_pkg::OP_INS_END:
                    begin
                        if (stat.full)
                        begin
                            res_next   = bdll_pkg::ST_FULL;
                            state_next = bdll_pkg::S_RESP;
                        end
                        else
                            state_next = bdll_pkg::S_INS_SCAN;
                    end
                    bdll_pkg::OP_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            res_next   = bdll_pkg::ST_EMPTY;
                            state_next = bdll_pkg::S_RESP;
                        end
                        else if (stat.pos_bad)
                        begin
                            res_next   = bdll_pkg::ST_RANGE;
                            state_next = bdll_pkg::S_RESP;
                        end
                        else
                            state_next = bdll_pkg::S_DEL_WALK;
                    end
                    default:
                    begin
                        if (stat.empty)
                        begin
                            res_next   = bdll_pkg::ST_EMPTY;
                            state_next = bdll_pkg::S_RESP;
                        end
                        else
                            state_next = bdll_pkg::S_DISP;
                    end
                endcase
            end
            bdll_pkg::S_INS_SCAN:
            begin
                if (stat.cand_ready)
                    state_next = bdll_pkg::S_INS_LINK;
            end
            bdll_pkg::S_INS_LINK:
                state_next = bdll_pkg::S_RESP;
            bdll_pkg::S_DEL_WALK:
            begin
                if (stat.steps_zero)
                    state_next = bdll_pkg::S_RESP;
            end
            bdll_pkg::S_DISP:
            begin
                if (stat.out_free && stat.disp_last)
                    state_next = bdll_pkg::S_IDLE;
            end
            bdll_pkg::S_RESP:
            begin
                if (stat.out_free)
                    state_next = bdll_pkg::S_IDLE;
            end
            default:
                state_next = bdll_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.emit_status = res_reg;
        case (state_reg)
            bdll_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bdll_pkg::S_INS_SCAN:
                cmd.scan_step = 1'b1;
            bdll_pkg::S_INS_LINK:
                cmd.link = 1'b1;
            bdll_pkg::S_DEL_WALK:
            begin
                cmd.rd_cur    = 1'b1;
                cmd.unlink    = stat.steps_zero;
                cmd.walk_step = !stat.steps_zero;
            end
            bdll_pkg::S_DISP:
            begin
                cmd.rd_cur    = 1'b1;
                cmd.disp_emit = stat.out_free;
            end
            bdll_pkg::S_RESP:
                cmd.emit = stat.out_free;
            default:
                cmd.rd_cur = 1'b0;
        endcase
    end

endmodule

/* src/bdll_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_dpath
// Node store, link memories, free map, list pointers and output register.
// ----------------------------------------------------------------------------
module bdll_dpath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bdll_pkg::ctl_cmd_t                 cmd,
    output bdll_pkg::dp_stat_t                 stat,
    input  logic [bdll_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [bdll_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bdll_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [bdll_pkg::STAT_W-1:0]        m_tuser,
    output logic                               m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > bdll_pkg::POS_W) ? CW : bdll_pkg::POS_W;
    localparam int XW = (CW > bdll_pkg::OUT_CNT_W) ? CW : bdll_pkg::OUT_CNT_W;
    localparam int VW = bdll_pkg::VAL_W;
    localparam int QW = bdll_pkg::POS_W;

    // storage
    logic [VW-1:0] val_mem  [CAPACITY];
    logic [IW-1:0] nxt_mem  [CAPACITY];
    logic [IW-1:0] prv_mem  [CAPACITY];
    logic          free_mem [CAPACITY];

    logic [VW-1:0] val_rd_reg;
    logic [IW-1:0] nxt_rd_reg, prv_rd_reg;
    logic          free_rd_reg;

    // control state
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next, hwm_reg, hwm_next, scan_reg, scan_next;
    logic          chk_vld_reg, chk_vld_next, out_vld_reg, out_vld_next;

    // work registers
    bdll_pkg::op_t    op_reg, op_next;
    logic signed [VW-1:0] value_reg, value_next;
    logic [IW-1:0]    chk_idx_reg, chk_idx_next, node_reg, node_next, cur_reg, cur_next;
    logic [QW-1:0]    steps_reg, steps_next;
    logic [CW-1:0]    remain_reg, remain_next;

    bdll_pkg::stat_t      out_stat_reg, out_stat_next;
    logic signed [VW-1:0] out_val_reg, out_val_next;
    logic [bdll_pkg::OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                 out_last_reg, out_last_next;

    // memory ports
    logic [IW-1:0] rd_addr;
    logic          val_we, nxt_we, prv_we, free_we, free_wd;
    logic [IW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, free_wa;

    logic [QW-1:0] in_pos;
    logic          found, exhausted;
    logic [XW-1:0] cnt_ext;

    assign in_pos    = s_tdata[VW +: QW];
    assign found     = chk_vld_reg && free_rd_reg;
    assign exhausted = (scan_reg == hwm_reg);
    assign cnt_ext   = XW'(count_next);

    always_comb
    begin
        if (cmd.walk_step || cmd.disp_emit)
            rd_addr = nxt_rd_reg;
        else if (cmd.rd_cur)
            rd_addr = cur_reg;
        else
            rd_addr = head_reg;
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.pos_bad    = (PW'(steps_reg) >= PW'(count_reg));
        stat.cand_ready = found || exhausted;
        stat.steps_zero = (steps_reg == '0);
        stat.disp_last  = (remain_reg == CW'(1));
        stat.out_free   = !out_vld_reg || m_tready;
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        hwm_next      = hwm_reg;
        scan_next     = scan_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        remain_next   = remain_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_stat_next = out_stat_reg;
        out_val_next  = out_val_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;

        val_we  = 1'b0;
        nxt_we  = 1'b0;
        nxt_wa  = node_reg;
        nxt_wd  = head_reg;
        prv_we  = 1'b0;
        prv_wa  = head_reg;
        prv_wd  = node_reg;
        free_we = 1'b0;
        free_wa = node_reg;
        free_wd = 1'b0;

        if (cmd.load)
        begin
            op_next      = bdll_pkg::op_t'(s_tuser);
            value_next   = s_tdata[VW-1:0];
            steps_next   = (in_pos == '0) ? '0 : in_pos - QW'(1);
            cur_next     = head_reg;
            scan_next    = '0;
            chk_vld_next = 1'b0;
            remain_next  = count_reg;
        end

        // lowest free node: nodes at or above the high-water mark were never used
        if (cmd.scan_step)
        begin
            if (found)
            begin
                node_next    = chk_idx_reg;
                chk_vld_next = 1'b0;
            end
            else if (exhausted)
            begin
                node_next    = hwm_reg[IW-1:0];
                hwm_next     = hwm_reg + CW'(1);
                chk_vld_next = 1'b0;
            end
            else
            begin
                chk_idx_next = scan_reg[IW-1:0];
                chk_vld_next = 1'b1;
                scan_next    = scan_reg + CW'(1);
            end
        end

        if (cmd.link)
        begin
            val_we     = 1'b1;
            free_we    = 1'b1;
            free_wa    = node_reg;
            free_wd    = 1'b0;
            count_next = count_reg + CW'(1);
            if (count_reg == '0)
            begin
                head_next = node_reg;
                tail_next = node_reg;
            end
            else if (op_reg == bdll_pkg::OP_INS_FRONT)
            begin
                nxt_we    = 1'b1;
                nxt_wa    = node_reg;
                nxt_wd    = head_reg;
                prv_we    = 1'b1;
                prv_wa    = head_reg;
                prv_wd    = node_reg;
                head_next = node_reg;
            end
            else
            begin
                prv_we    = 1'b1;
                prv_wa    = node_reg;
                prv_wd    = tail_reg;
                nxt_we    = 1'b1;
                nxt_wa    = tail_reg;
                nxt_wd    = node_reg;
                tail_next = node_reg;
            end
        end

        if (cmd.walk_step)
        begin
            cur_next   = nxt_rd_reg;
            steps_next = steps_reg - QW'(1);
        end

        // read data holds the links of cur_reg here
        if (cmd.unlink)
        begin
            free_we    = 1'b1;
            free_wa    = cur_reg;
            free_wd    = 1'b1;
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else if (cur_reg == head_reg)
                head_next = nxt_rd_reg;
            else if (cur_reg == tail_reg)
                tail_next = prv_rd_reg;
            else
            begin
                nxt_we = 1'b1;
                nxt_wa = prv_rd_reg;
                nxt_wd = nxt_rd_reg;
                prv_we = 1'b1;
                prv_wa = nxt_rd_reg;
                prv_wd = prv_rd_reg;
            end
        end

        if (cmd.disp_emit)
        begin
            out_vld_next  = 1'b1;
            out_stat_next = bdll_pkg::ST_OK;
            out_val_next  = val_rd_reg;
            out_cnt_next  = cnt_ext[bdll_pkg::OUT_CNT_W-1:0];
            out_last_next = (remain_reg == CW'(1));
            remain_next   = remain_reg - CW'(1);
            cur_next      = nxt_rd_reg;
        end

        if (cmd.emit)
        begin
            out_vld_next  = 1'b1;
            out_stat_next = cmd.emit_status;
            out_val_next  = '0;
            out_cnt_next  = cnt_ext[bdll_pkg::OUT_CNT_W-1:0];
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            hwm_reg     <= '0;
            scan_reg    <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            hwm_reg     <= hwm_next;
            scan_reg    <= scan_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        chk_idx_reg  <= chk_idx_next;
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        remain_reg   <= remain_next;
        out_stat_reg <= out_stat_next;
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[node_reg] <= value_reg;
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        nxt_rd_reg <= nxt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
            prv_mem[prv_wa] <= prv_wd;
        prv_rd_reg <= prv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_wa] <= free_wd;
        free_rd_reg <= free_mem[scan_reg[IW-1:0]];
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(bdll_pkg::OUT_TDATA_W - VW - bdll_pkg::OUT_CNT_W){1'b0}},
                       out_cnt_reg, out_val_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* src/bounded_doubly_linked_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list
// Ordered list of signed 32-bit values kept as a doubly linked list of
// CAPACITY nodes: insert front/end, delete at position, display.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; a new word is taken while the last
// result still sits in the output register. Every step of a walk is one read
// of the link memories, and finding a free node reads the free map one entry
// per cycle up to the high-water mark of nodes ever used. Any result can be
// held by an output stall. No clearing pass after reset: the node store is
// used only where it was written. Display of a non-empty list produces one
// result word per entry with tlast on the final one; every other operation
// produces one word.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list
#(
    parameter int CAPACITY = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bdll_pkg::IN_TDATA_W-1:0]  s_tdata,   // value[31:0], position[39:32]
    input  logic [bdll_pkg::OP_W-1:0]        s_tuser,   // operation[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bdll_pkg::OUT_TDATA_W-1:0] m_tdata,   // item_value[31:0], item_count[36:32]
    output logic [bdll_pkg::STAT_W-1:0]      m_tuser,   // status[1:0]
    output logic                             m_tlast
);

    bdll_pkg::ctl_cmd_t cmd;
    bdll_pkg::dp_stat_t stat;

    bdll_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdll_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/bdll_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_checker
// Port-level checks on the result stream of the linked list block.
// ----------------------------------------------------------------------------
module bdll_checker
#(
    parameter int CAPACITY = 16
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bdll_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [bdll_pkg::STAT_W-1:0]      m_tuser,
    input logic                             m_tlast
);

    localparam int CNT_MAX = (CAPACITY > 31) ? 31 : CAPACITY;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a refusal is always a single, final word with no value
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != bdll_pkg::ST_OK) |-> m_tlast && (m_tdata[31:0] == 32'd0))
        else $error("error status on non-final word or with a value");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == bdll_pkg::ST_EMPTY) |-> (m_tdata[36:32] == 5'd0))
        else $error("empty status with nonzero count");

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[36:32] <= 5'(CNT_MAX)))
        else $error("entry count above capacity");

endmodule

bind bounded_doubly_linked_list bdll_checker
#(
    .CAPACITY (CAPACITY)
)
u_bdll_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
